// ----- rtl/ucd_pkg.sv -----
// ----------------------------------------------------------------------------
// ucd_pkg: shared types and constants of the unix time to civil date unit
// Reciprocal multipliers for the constant divisions and the stage structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ucd_pkg;

  // bias of 32768 days makes the local time non-negative in 33 bits
  localparam logic [32:0] TIME_BIAS = 33'd2831155200;

  // seconds per day is 128 * 675; floor(v / 675) for a 26-bit v
  localparam int unsigned  DAY_SH  = 36;
  localparam logic [26:0]  DAY_MUL = 27'(((64'd1 << DAY_SH) + 64'd674) / 64'd675);
  localparam logic [9:0]   DAY_DIV = 10'd675;

  // days shift minus the day bias, and era boundaries of the shifted day count
  localparam logic [19:0]  Z_SHIFT    = 20'd686700;
  localparam logic [19:0]  ERA4_START = 20'd584388;
  localparam logic [19:0]  ERA5_START = 20'd730485;

  // day of era divided by 36524, 73048, 109572 and 146096
  localparam logic [17:0]  CENT1    = 18'd36524;
  localparam logic [17:0]  CENT2    = 18'd73048;
  localparam logic [17:0]  CENT3    = 18'd109572;
  localparam logic [17:0]  ERA_LAST = 18'd146096;

  // floor(x / 365) for a 16-bit x (used on doe / 4)
  localparam int unsigned  Q365_SH  = 25;
  localparam logic [16:0]  Q365_MUL = 17'(((64'd1 << Q365_SH) + 64'd364) / 64'd365);

  // floor(x / 365) for an 18-bit x
  localparam int unsigned  Y365_SH  = 27;
  localparam logic [18:0]  Y365_MUL = 19'(((64'd1 << Y365_SH) + 64'd364) / 64'd365);

  // floor(x / 153) for an 11-bit x
  localparam int unsigned  M153_SH  = 19;
  localparam logic [11:0]  M153_MUL = 12'(((64'd1 << M153_SH) + 64'd152) / 64'd153);

  // floor(x / 5) for an 11-bit x
  localparam int unsigned  D5_SH  = 14;
  localparam logic [11:0]  D5_MUL = 12'(((64'd1 << D5_SH) + 64'd4) / 64'd5);

  // floor(x / 3600) for a 17-bit x
  localparam int unsigned  HOUR_SH  = 29;
  localparam logic [17:0]  HOUR_MUL = 18'(((64'd1 << HOUR_SH) + 64'd3599) / 64'd3600);

  // floor(x / 60) for a 12-bit x
  localparam int unsigned  MIN_SH  = 18;
  localparam logic [12:0]  MIN_MUL = 13'(((64'd1 << MIN_SH) + 64'd59) / 64'd60);

  // floor(x / 7) for a 16-bit x
  localparam int unsigned  WD_SH  = 19;
  localparam logic [16:0]  WD_MUL = 17'(((64'd1 << WD_SH) + 64'd6) / 64'd7);

  // biased day index plus 3 is congruent to days plus 4 modulo 7
  localparam logic [15:0]  WD_OFFSET = 16'd3;

  // stage counts of the date path and of the clock path before padding
  localparam int unsigned  DATE_LAT = 7;
  localparam int unsigned  CLK_LAT  = 3;

  // split of local time into biased day index and second of day
  typedef struct packed {
    logic [15:0] day_idx;
    logic [16:0] sod;
  } day_split_t;

  typedef struct packed {
    logic [10:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
  } civil_date_t;

  typedef struct packed {
    logic [2:0] weekday;
    logic [4:0] hour;
    logic [5:0] minute;
  } clock_fields_t;

endpackage

// ----- rtl/ucd_day_split.sv -----
// ----------------------------------------------------------------------------
// ucd_day_split: local time to day index and second of day
// Adds the offset and a day bias, then floor-divides by 86400 in three stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ucd_day_split (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic signed [31:0]  unix_time,
  input  logic signed [16:0]  zone_offset,
  output logic                out_valid,
  output ucd_pkg::day_split_t out_data
);

  logic        v1_r, v2_r, v3_r;
  logic [32:0] local_r;
  logic [32:0] local_nxt;
  logic [25:0] hi_r;
  logic [6:0]  lo_r;
  logic [15:0] q_r;
  logic [52:0] q_prod;
  logic [15:0] q_nxt;
  logic [25:0] rem_full;
  ucd_pkg::day_split_t out_r;
  ucd_pkg::day_split_t out_nxt;

  // stage 1: biased local time, always non-negative
  assign local_nxt = {unix_time[31], unix_time} + {{16{zone_offset[16]}}, zone_offset}
                     + ucd_pkg::TIME_BIAS;

  // stage 2: quotient by 675 of the time shifted down by 7
  assign q_prod = 53'(local_r[32:7]) * 53'(ucd_pkg::DAY_MUL);
  assign q_nxt  = q_prod[ucd_pkg::DAY_SH +: 16];

  // stage 3: remainder rebuilt into second of day
  assign rem_full        = hi_r - 26'(q_r) * 26'(ucd_pkg::DAY_DIV);
  assign out_nxt.day_idx = q_r;
  assign out_nxt.sod     = {rem_full[9:0], lo_r};

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // data stages
  always_ff @(posedge clk) begin
    local_r <= local_nxt;
    hi_r    <= local_r[32:7];
    lo_r    <= local_r[6:0];
    q_r     <= q_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = v3_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/ucd_civil_date.sv -----
// ----------------------------------------------------------------------------
// ucd_civil_date: biased day index to year, month and day of month
// Era-based civil-from-days conversion in seven register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ucd_civil_date (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [15:0]          day_idx,
  output logic                 out_valid,
  output ucd_pkg::civil_date_t out_data
);

  logic [ucd_pkg::DATE_LAT-1:0] vld_r;

  // stage a
  logic [19:0] z;
  logic        era5_nxt;
  logic [17:0] doe_nxt;
  logic        era5_a_r;
  logic [17:0] doe_a_r;

  // stage b
  logic [32:0] q365_prod;
  logic [6:0]  div1460_nxt;
  logic [2:0]  div36524_nxt;
  logic        last_nxt;
  logic        era5_b_r;
  logic [17:0] doe_b_r;
  logic [6:0]  div1460_r;
  logic [2:0]  div36524_r;
  logic        last_r;

  // stage c
  logic [17:0] num_nxt;
  logic        era5_c_r;
  logic [17:0] doe_c_r;
  logic [17:0] num_r;

  // stage d
  logic [36:0] y365_prod;
  logic [8:0]  yoe_nxt;
  logic        era5_d_r;
  logic [17:0] doe_d_r;
  logic [8:0]  yoe_d_r;

  // stage e
  logic [1:0]  cent;
  logic [17:0] yday;
  logic [8:0]  doy_nxt;
  logic        era5_e_r;
  logic [8:0]  yoe_e_r;
  logic [8:0]  doy_e_r;

  // stage f
  logic [10:0] mx;
  logic [22:0] mp_prod;
  logic [3:0]  mp_nxt;
  logic        era5_f_r;
  logic [8:0]  yoe_f_r;
  logic [8:0]  doy_f_r;
  logic [3:0]  mp_f_r;

  // stage g
  logic [10:0] dx;
  logic [22:0] d5_prod;
  logic [8:0]  mstart;
  logic [8:0]  dd_full;
  logic        early;
  ucd_pkg::civil_date_t out_nxt;
  ucd_pkg::civil_date_t out_r;

  // stage a: shifted day count, era and day of era
  assign z        = 20'(day_idx) + ucd_pkg::Z_SHIFT;
  assign era5_nxt = (z >= ucd_pkg::ERA5_START);
  assign doe_nxt  = 18'(z - (era5_nxt ? ucd_pkg::ERA5_START : ucd_pkg::ERA4_START));

  // stage b: leap corrections of the day of era
  assign q365_prod    = 33'(doe_a_r[17:2]) * 33'(ucd_pkg::Q365_MUL);
  assign div1460_nxt  = q365_prod[ucd_pkg::Q365_SH +: 7];
  assign div36524_nxt = 3'(doe_a_r >= ucd_pkg::CENT1) + 3'(doe_a_r >= ucd_pkg::CENT2)
                      + 3'(doe_a_r >= ucd_pkg::CENT3) + 3'(doe_a_r >= ucd_pkg::ERA_LAST);
  assign last_nxt     = (doe_a_r == ucd_pkg::ERA_LAST);

  // stage c: corrected day count
  assign num_nxt = doe_b_r - 18'(div1460_r) + 18'(div36524_r) - 18'(last_r);

  // stage d: year of era
  assign y365_prod = 37'(num_r) * 37'(ucd_pkg::Y365_MUL);
  assign yoe_nxt   = y365_prod[ucd_pkg::Y365_SH +: 9];

  // stage e: day of year, counted from march 1
  assign cent    = 2'(yoe_d_r >= 9'd100) + 2'(yoe_d_r >= 9'd200) + 2'(yoe_d_r >= 9'd300);
  assign yday    = 18'(yoe_d_r) * 18'd365 + 18'(yoe_d_r[8:2]) - 18'(cent);
  assign doy_nxt = 9'(doe_d_r - yday);

  // stage f: month index, march is 0
  assign mx      = 11'(doy_e_r) * 11'd5 + 11'd2;
  assign mp_prod = 23'(mx) * 23'(ucd_pkg::M153_MUL);
  assign mp_nxt  = mp_prod[ucd_pkg::M153_SH +: 4];

  // stage g: day of month, month and year
  assign dx      = 11'(mp_f_r) * 11'd153 + 11'd2;
  assign d5_prod = 23'(dx) * 23'(ucd_pkg::D5_MUL);
  assign mstart  = d5_prod[ucd_pkg::D5_SH +: 9];
  assign dd_full = doy_f_r - mstart + 9'd1;
  assign early   = (mp_f_r >= 4'd10);

  always_comb begin
    out_nxt.day_of_month = dd_full[4:0];
    out_nxt.month        = early ? (mp_f_r - 4'd9) : (mp_f_r + 4'd3);
    out_nxt.year         = 11'(yoe_f_r) + (era5_f_r ? 11'd2000 : 11'd1600) + 11'(early);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[ucd_pkg::DATE_LAT-2:0], in_valid};
    end
  end

  // data stages
  always_ff @(posedge clk) begin
    era5_a_r   <= era5_nxt;
    doe_a_r    <= doe_nxt;

    era5_b_r   <= era5_a_r;
    doe_b_r    <= doe_a_r;
    div1460_r  <= div1460_nxt;
    div36524_r <= div36524_nxt;
    last_r     <= last_nxt;

    era5_c_r   <= era5_b_r;
    doe_c_r    <= doe_b_r;
    num_r      <= num_nxt;

    era5_d_r   <= era5_c_r;
    doe_d_r    <= doe_c_r;
    yoe_d_r    <= yoe_nxt;

    era5_e_r   <= era5_d_r;
    yoe_e_r    <= yoe_d_r;
    doy_e_r    <= doy_nxt;

    era5_f_r   <= era5_e_r;
    yoe_f_r    <= yoe_e_r;
    doy_f_r    <= doy_e_r;
    mp_f_r     <= mp_nxt;

    out_r      <= out_nxt;
  end

  assign out_valid = vld_r[ucd_pkg::DATE_LAT-1];
  assign out_data  = out_r;

endmodule

// ----- rtl/ucd_clock_fields.sv -----
// ----------------------------------------------------------------------------
// ucd_clock_fields: weekday, hour and minute
// Three compute stages, then a delay line to match the date path.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ucd_clock_fields (
  input  logic                   clk,
  input  ucd_pkg::day_split_t    in_data,
  output ucd_pkg::clock_fields_t out_data
);

  localparam int unsigned PAD = ucd_pkg::DATE_LAT - ucd_pkg::CLK_LAT;

  // stage 1
  logic [34:0] hour_prod;
  logic [15:0] wx;
  logic [32:0] wq_prod;
  logic [4:0]  hour_1_r;
  logic [16:0] sod_1_r;
  logic [15:0] wx_1_r;
  logic [13:0] wq_1_r;

  // stage 2
  logic [16:0] msec_full;
  logic [15:0] wd_full;
  logic [4:0]  hour_2_r;
  logic [11:0] msec_2_r;
  logic [2:0]  wd_2_r;

  // stage 3
  logic [24:0] min_prod;
  ucd_pkg::clock_fields_t f3_nxt;
  ucd_pkg::clock_fields_t f3_r;

  ucd_pkg::clock_fields_t pad_r [PAD];

  // stage 1: hour and week quotient
  assign hour_prod = 35'(in_data.sod) * 35'(ucd_pkg::HOUR_MUL);
  assign wx        = in_data.day_idx + ucd_pkg::WD_OFFSET;
  assign wq_prod   = 33'(wx) * 33'(ucd_pkg::WD_MUL);

  // stage 2: second of hour and weekday
  assign msec_full = sod_1_r - 17'(hour_1_r) * 17'd3600;
  assign wd_full   = wx_1_r - 16'(wq_1_r) * 16'd7;

  // stage 3: minute
  assign min_prod = 25'(msec_2_r) * 25'(ucd_pkg::MIN_MUL);

  always_comb begin
    f3_nxt.weekday = wd_2_r;
    f3_nxt.hour    = hour_2_r;
    f3_nxt.minute  = min_prod[ucd_pkg::MIN_SH +: 6];
  end

  // compute stages
  always_ff @(posedge clk) begin
    hour_1_r <= hour_prod[ucd_pkg::HOUR_SH +: 5];
    sod_1_r  <= in_data.sod;
    wx_1_r   <= wx;
    wq_1_r   <= wq_prod[ucd_pkg::WD_SH +: 14];

    hour_2_r <= hour_1_r;
    msec_2_r <= msec_full[11:0];
    wd_2_r   <= wd_full[2:0];

    f3_r     <= f3_nxt;
  end

  // delay line to line up with the date fields
  always_ff @(posedge clk) begin
    pad_r[0] <= f3_r;
    for (int i = 1; i < PAD; i++) begin
      pad_r[i] <= pad_r[i-1];
    end
  end

  assign out_data = pad_r[PAD-1];

endmodule

// ----- rtl/unix_time_to_civil_date_unit.sv -----
// ----------------------------------------------------------------------------
// unix_time_to_civil_date_unit: signed unix time to local civil date and time
// Each accepted start passes the day split, then the date and clock paths, to out_valid.
// Throughput one item per cycle, set by the ten-stage pipeline; busy stays low.
// Synchronous active-low reset clears the valid bits and sets the offset to 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module unix_time_to_civil_date_unit (
  input  logic               clk,
  input  logic               rst_n,

  // item input
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_unix_time,

  // result output
  output logic               out_valid,
  output logic [10:0]        out_year,
  output logic [3:0]         out_month,
  output logic [4:0]         out_day_of_month,
  output logic [2:0]         out_weekday,
  output logic [4:0]         out_hour,
  output logic [5:0]         out_minute,

  // offset register write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [16:0] cfg_zone_offset
);

  logic signed [16:0]     zone_offset_r;
  logic                   split_valid;
  ucd_pkg::day_split_t    split_data;
  ucd_pkg::civil_date_t   date_data;
  ucd_pkg::clock_fields_t clock_data;

  // pipeline never stalls
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // offset register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_offset_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      zone_offset_r <= cfg_zone_offset;
    end
  end

  ucd_day_split u_split (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (start && !busy),
    .unix_time   (in_unix_time),
    .zone_offset (zone_offset_r),
    .out_valid   (split_valid),
    .out_data    (split_data)
  );

  ucd_civil_date u_date (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (split_valid),
    .day_idx   (split_data.day_idx),
    .out_valid (out_valid),
    .out_data  (date_data)
  );

  ucd_clock_fields u_clock (
    .clk      (clk),
    .in_data  (split_data),
    .out_data (clock_data)
  );

  // result fields
  assign out_year         = date_data.year;
  assign out_month        = date_data.month;
  assign out_day_of_month = date_data.day_of_month;
  assign out_weekday      = clock_data.weekday;
  assign out_hour         = clock_data.hour;
  assign out_minute       = clock_data.minute;

endmodule

// ----- test/civil_date_checker.sv -----
// ----------------------------------------------------------------------------
// civil_date_checker: scoreboard for the unix time to civil date unit
// Watches the item, result and offset channels, predicts the local civil date
// and time of each accepted item, and compares results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module civil_date_checker (
  input  logic               clk,
  input  logic               rst_n,

  // item channel
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] in_unix_time,

  // result channel
  input  logic               out_valid,
  input  logic [10:0]        out_year,
  input  logic [3:0]         out_month,
  input  logic [4:0]         out_day_of_month,
  input  logic [2:0]         out_weekday,
  input  logic [4:0]         out_hour,
  input  logic [5:0]         out_minute,

  // offset register channel
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic signed [16:0] cfg_zone_offset,

  output int                 fail_count,
  output int                 pending
);

  localparam longint SECONDS_PER_DAY  = 86400;
  localparam longint SECONDS_PER_HOUR = 3600;
  localparam longint SECONDS_PER_MIN  = 60;
  localparam longint EPOCH_DAY_SHIFT  = 719468;
  localparam longint DAYS_PER_ERA     = 146097;

  typedef struct packed {
    logic [10:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } civil_time_t;

  civil_time_t        date_q[$];
  logic signed [16:0] tz_offset;

  // quotient rounded toward minus infinity, divisor always positive here
  function automatic longint floor_quot(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  // era-based day-to-date split on the floor-divided local day number
  function automatic civil_time_t civil_from_unix(input logic signed [31:0] unix_t,
                                                  input logic signed [16:0] ofs);
    civil_time_t r;
    longint loc, days, sod, z, era, doe, yoe, doy, mp, dd, mm, yy, wd;
    loc  = longint'(unix_t) + longint'(ofs);
    days = floor_quot(loc, SECONDS_PER_DAY);
    sod  = loc - days * SECONDS_PER_DAY;
    z    = days + EPOCH_DAY_SHIFT;
    era  = floor_quot(z, DAYS_PER_ERA);
    doe  = z - era * DAYS_PER_ERA;
    yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp   = (5 * doy + 2) / 153;
    dd   = doy - (153 * mp + 2) / 5 + 1;
    mm   = (mp < 10) ? mp + 3 : mp - 9;
    yy   = yoe + era * 400 + ((mm <= 2) ? 1 : 0);
    // day 0 was a thursday
    wd   = (days + 4) - floor_quot(days + 4, 7) * 7;
    r.year         = 11'(yy);
    r.month        = 4'(mm);
    r.day_of_month = 5'(dd);
    r.weekday      = 3'(wd);
    r.hour         = 5'(sod / SECONDS_PER_HOUR);
    r.minute       = 6'((sod % SECONDS_PER_HOUR) / SECONDS_PER_MIN);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [10:0] want,
                             input logic [10:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    tz_offset  = '0;
  end

  // compare results first, then record new items and offset writes
  always @(posedge clk) begin
    civil_time_t want;
    if (!rst_n) begin
      date_q.delete();
      tz_offset = '0;
    end else begin
      if (out_valid) begin
        if (date_q.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual %0d-%0d-%0d %0d:%0d",
                   $time, out_year, out_month, out_day_of_month, out_hour, out_minute);
          fail_count++;
        end else begin
          want = date_q.pop_front();
          check_field("year",         want.year,         out_year);
          check_field("month",        want.month,        out_month);
          check_field("day_of_month", want.day_of_month, out_day_of_month);
          check_field("weekday",      want.weekday,      out_weekday);
          check_field("hour",         want.hour,         out_hour);
          check_field("minute",       want.minute,       out_minute);
        end
      end
      if (start && !busy) date_q.push_back(civil_from_unix(in_unix_time, tz_offset));
      if (cfg_valid && cfg_ready) tz_offset = cfg_zone_offset;
    end
    pending = date_q.size();
  end

endmodule

// ----- test/unix_time_to_civil_date_unit_tb.sv -----
// ----------------------------------------------------------------------------
// unix_time_to_civil_date_unit_tb: stimulus and verdict for the date unit
// Directed edge timestamps, then random timestamps under several utc offsets,
// with random sender gaps; the checker module predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module unix_time_to_civil_date_unit_tb;

  localparam int     RESET_CYCLES    = 11;
  localparam int     ITEMS_PER_PHASE = 210;
  localparam int     NUM_PHASES      = 8;
  localparam int     TAIL_CYCLES     = 20;
  localparam int     CYCLE_LIMIT     = 200000;
  localparam longint I32_MAX         = 64'sd2147483647;
  localparam longint I32_MIN         = -64'sd2147483648;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [31:0] in_unix_time;
  logic               out_valid;
  logic [10:0]        out_year;
  logic [3:0]         out_month;
  logic [4:0]         out_day_of_month;
  logic [2:0]         out_weekday;
  logic [4:0]         out_hour;
  logic [5:0]         out_minute;
  logic               cfg_valid;
  logic               cfg_ready;
  logic signed [16:0] cfg_zone_offset;

  int                 fail_count;
  int                 pending;
  int                 cycle_count = 0;
  logic signed [16:0] cur_offset = '0;
  bit                 burst = 1'b0;

  always #4 clk = ~clk;

  unix_time_to_civil_date_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_unix_time     (in_unix_time),
    .out_valid        (out_valid),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day_of_month (out_day_of_month),
    .out_weekday      (out_weekday),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_zone_offset  (cfg_zone_offset)
  );

  civil_date_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_unix_time     (in_unix_time),
    .out_valid        (out_valid),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day_of_month (out_day_of_month),
    .out_weekday      (out_weekday),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_zone_offset  (cfg_zone_offset),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // offer one item after an idle gap; returns at the falling edge after acceptance
  task automatic push_time(input logic signed [31:0] unix_t, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start        <= 1'b1;
    in_unix_time <= unix_t;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_all_results();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_offset(input logic signed [16:0] ofs);
    cfg_valid       <= 1'b1;
    cfg_zone_offset <= ofs;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid  <= 1'b0;
    cur_offset  = ofs;
  endtask

  // mix of full-range values, range ends, local midnights and times near the epoch
  function automatic logic signed [31:0] pick_unix_time();
    longint d, v;
    case ($urandom_range(0, 4))
      0, 1: v = longint'(int'($urandom));
      2: begin
        if ($urandom_range(0, 1)) v = I32_MAX - longint'($urandom_range(0, 200000));
        else v = I32_MIN + longint'($urandom_range(0, 200000));
      end
      3: begin
        d = longint'($urandom_range(0, 49710)) - 24855;
        v = d * 86400 - longint'(cur_offset) + longint'($urandom_range(0, 4)) - 2;
      end
      default: v = longint'($urandom_range(0, 400000)) - 200000;
    endcase
    if (v > I32_MAX || v < I32_MIN) v = longint'(int'($urandom));
    return 32'(v);
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 39) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 10);
  endfunction

  initial begin
    logic signed [31:0] edge_times[$];
    logic signed [16:0] offsets[NUM_PHASES];

    rst_n           = 1'b0;
    start           = 1'b0;
    in_unix_time    = '0;
    cfg_valid       = 1'b0;
    cfg_zone_offset = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // epoch, day edges, range ends, leap day, era start, year change, bit patterns
    edge_times = '{32'sd0, -32'sd1, 32'sd1, 32'sd86399, 32'sd86400, -32'sd86400,
                   -32'sd86401, 32'sh7fffffff, 32'sh80000000, 32'sd951782400,
                   32'sd951868799, 32'sd951868800, 32'sd946684799, 32'sd946684800,
                   32'sd68169600, 32'sh55555555, 32'shAAAAAAAA, 32'sd1234567890};
    foreach (edge_times[i]) begin
      push_time(edge_times[i], (i < 9) ? 0 : $urandom_range(0, 10));
      if (i == 9) wait_all_results();
    end

    offsets = '{-17'sd43200, 17'sd50400, -17'sd65536, 17'sd65535, 17'sd0,
                17'sd19800, -17'sd1, 17'($urandom)};
    foreach (offsets[p]) begin
      wait_all_results();
      write_offset(offsets[p]);
      push_time(32'sh80000000, 0);
      push_time(32'sh7fffffff, 0);
      repeat (ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 59) == 0) wait_all_results();
        push_time(pick_unix_time(), pick_gap());
      end
    end

    wait_all_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
